// File: src/crtc_pkg.sv
// Shared types, constants and helper functions of the clock ratio time converter.
`timescale 1ns / 1ps

package crtc_pkg;

  localparam int TICK_W     = 64;
  localparam int TIME_W_DEF = 64;
  localparam int HZ_W       = 32;
  localparam int DRAW_W     = 24;
  localparam int OP_W       = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = TICK_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [HZ_W-1:0]   hz_t;
  typedef logic [DRAW_W-1:0] draw_t;
  typedef logic [MODE_W-1:0] mode_t;

  // operation codes of a request
  localparam logic [OP_W-1:0] OP_SYNC     = 2'd0;
  localparam logic [OP_W-1:0] OP_DEADLINE = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART  = 2'd2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_HZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS = 2'd2;

  // monitor modes
  localparam mode_t MODE_640 = 2'd0;
  localparam mode_t MODE_800 = 2'd1;

  localparam hz_t   CPU_HZ_RST = 32'd2000000;
  localparam mode_t MODE_RST   = 2'd2;
  localparam logic  ACCESS_RST = 1'b0;

  localparam int unsigned PCLK_640        = 25175000;
  localparam int unsigned PCLK_800        = 40000000;
  localparam int unsigned PCLK_1024       = 65000000;
  localparam int unsigned DIV_INTERLEAVED = 4;
  localparam int unsigned DIV_SINGLE      = 8;

  localparam draw_t DRAW_640_S  = DRAW_W'(PCLK_640 / DIV_SINGLE);
  localparam draw_t DRAW_640_I  = DRAW_W'(PCLK_640 / DIV_INTERLEAVED);
  localparam draw_t DRAW_800_S  = DRAW_W'(PCLK_800 / DIV_SINGLE);
  localparam draw_t DRAW_800_I  = DRAW_W'(PCLK_800 / DIV_INTERLEAVED);
  localparam draw_t DRAW_1024_S = DRAW_W'(PCLK_1024 / DIV_SINGLE);
  localparam draw_t DRAW_1024_I = DRAW_W'(PCLK_1024 / DIV_INTERLEAVED);

  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    tick_t   a;
    hz_t     b;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    tick_t res;
    hz_t   rem;
  } alu_rsp_t;

  // drawing clock rate for a monitor mode and access mode
  function automatic draw_t draw_hz(mode_t mode, logic access);
    draw_t f;
    priority if (mode == MODE_640) begin
      f = access ? DRAW_640_I : DRAW_640_S;
    end else if (mode == MODE_800) begin
      f = access ? DRAW_800_I : DRAW_800_S;
    end else begin
      f = access ? DRAW_1024_I : DRAW_1024_S;
    end
    return f;
  endfunction

  // a rate of zero counts as one hertz
  function automatic hz_t eff_hz(hz_t hz);
    return (hz == '0) ? hz_t'(1) : hz;
  endfunction

endpackage

// File: src/crtc_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
`timescale 1ns / 1ps

interface crtc_in_if;
  import crtc_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TICK_W-1:0] now;
  logic              busy_req;
  logic [TICK_W-1:0] busy_until;
  modport source (output valid, operation, now, busy_req, busy_until, input ready);
  modport sink   (input valid, operation, now, busy_req, busy_until, output ready);
endinterface

interface crtc_out_if;
  import crtc_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] deadline;
  logic              deadline_valid;
  modport source (output valid, tick_count, deadline, deadline_valid, input ready);
  modport sink   (input valid, tick_count, deadline, deadline_valid, output ready);
endinterface

interface crtc_cfg_if;
  import crtc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/crtc_alu.sv
// Shared iterative unit: restoring divide 64/32 and shift-add multiply 64x32 mod 2^64.
`timescale 1ns / 1ps

module crtc_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  crtc_pkg::alu_req_t  req,
  output crtc_pkg::alu_rsp_t  rsp
);
  import crtc_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  alu_op_t          op_r, op_nxt;
  tick_t            a_r, a_nxt;
  hz_t              b_r, b_nxt;
  tick_t            acc_r, acc_nxt;
  hz_t              rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [HZ_W:0]   rs;
  logic [HZ_W+1:0] diff;
  logic            ge;
  hz_t             b_shr;

  always_comb begin
    rs    = {rem_r, a_r[TICK_W-1]};
    diff  = {1'b0, rs} - {2'b00, b_r};
    ge    = ~diff[HZ_W+1];
    b_shr = {1'b0, b_r[HZ_W-1:1]};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      unique case (op_r)
        ALU_DIV: begin
          // shift one dividend bit into the partial remainder, subtract if it fits
          rem_nxt = ge ? diff[HZ_W-1:0] : rs[HZ_W-1:0];
          a_nxt   = {a_r[TICK_W-2:0], ge};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        ALU_MUL: begin
          if (b_r[0]) begin
            acc_nxt = acc_r + a_r;
          end
          a_nxt = {a_r[TICK_W-2:0], 1'b0};
          b_nxt = b_shr;
          // stop once no multiplier bits are left
          if (b_shr == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = (op_r == ALU_DIV) ? a_r : acc_r;
  assign rsp.rem  = rem_r;

endmodule

// File: src/clock_ratio_time_converter.sv
// Top level of the clock ratio time converter: sequencer, time state and channel ports.
`timescale 1ns / 1ps

// Converts CPU time in T-states into an exact count of drawing-clock ticks, carrying the
// division remainder between requests so no tick is lost. The drawing rate is the pixel
// clock of the selected monitor mode divided by 8 (single access) or 4 (interleaved).
// Requests: sync advances the count to "now", deadline returns the earliest CPU time at
// which the count reaches busy_until (at least now + 1) if busy_req is set and no deadline
// otherwise, restart clears the count at "now". Every request yields exactly one result.
// The block works on one request at a time through a single shared divide/multiply unit
// stepping one bit per cycle: a sync that moves time forward runs a divide, two multiplies
// and a second divide; a busy deadline that still has ticks to wait runs a multiply and a
// divide; every other request uses no unit. The result register lets the next request be
// taken while a result still waits for out_ch.ready. Issue a sync before writing cpu_hz,
// mode_index or access_mode, and write registers only while idle.
module clock_ratio_time_converter #(
  parameter int unsigned TIME_WIDTH = crtc_pkg::TIME_W_DEF
) (
  input logic        clk,
  input logic        rst_n,
  crtc_in_if.sink    in_ch,
  crtc_out_if.source out_ch,
  crtc_cfg_if.sink   cfg_ch
);
  import crtc_pkg::*;

  typedef logic [TIME_WIDTH-1:0] time_t;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_SY_DIV  = 10'b00_0000_0010,
    ST_SY_MULQ = 10'b00_0000_0100,
    ST_SY_MULR = 10'b00_0000_1000,
    ST_SY_REM  = 10'b00_0001_0000,
    ST_DL_MUL  = 10'b00_0010_0000,
    ST_DL_ADJ  = 10'b00_0100_0000,
    ST_DL_DIV  = 10'b00_1000_0000,
    ST_DL_FIN  = 10'b01_0000_0000,
    ST_PUT     = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  hz_t   cpu_hz_r, cpu_hz_nxt;
  mode_t mode_r, mode_nxt;
  logic  access_r, access_nxt;

  // time state
  time_t last_r, last_nxt;
  tick_t total_r, total_nxt;
  hz_t   trem_r, trem_nxt;

  // working registers of the current request
  time_t pend_t_r, pend_t_nxt;
  tick_t scr_r, scr_nxt;
  time_t res_dl_r, res_dl_nxt;
  logic  res_dv_r, res_dv_nxt;

  // result register
  logic  out_valid_r, out_valid_nxt;
  tick_t out_tick_r, out_tick_nxt;
  time_t out_dl_r, out_dl_nxt;
  logic  out_dv_r, out_dv_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  hz_t   hz;
  draw_t f;
  draw_t f_m1;
  time_t t_in;
  time_t dt;
  time_t when;
  logic  in_acc;

  crtc_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    hz     = eff_hz(cpu_hz_r);
    f      = draw_hz(mode_r, access_r);
    f_m1   = f - 1'b1;
    t_in   = in_ch.now[TIME_WIDTH-1:0];
    dt     = t_in - last_r;
    when   = last_r + scr_r[TIME_WIDTH-1:0];
    in_acc = in_ch.valid && (state_r == ST_IDLE);

    state_nxt     = state_r;
    cpu_hz_nxt    = cpu_hz_r;
    mode_nxt      = mode_r;
    access_nxt    = access_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    trem_nxt      = trem_r;
    pend_t_nxt    = pend_t_r;
    scr_nxt       = scr_r;
    res_dl_nxt    = res_dl_r;
    res_dv_nxt    = res_dv_r;
    out_valid_nxt = out_valid_r;
    out_tick_nxt  = out_tick_r;
    out_dl_nxt    = out_dl_r;
    out_dv_nxt    = out_dv_r;
    alu_req       = '{start: 1'b0, op: ALU_DIV, a: '0, b: '0};

    // register writes; indexes past the list are dropped
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_CPU_HZ: cpu_hz_nxt = cfg_ch.data[HZ_W-1:0];
        CFG_MODE:   mode_nxt   = cfg_ch.data[MODE_W-1:0];
        CFG_ACCESS: access_nxt = cfg_ch.data[0];
        default:    ;
      endcase
    end

    // the result leaves when taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pend_t_nxt = t_in;
          res_dl_nxt = '0;
          res_dv_nxt = 1'b0;
          unique case (in_ch.operation)
            OP_SYNC: begin
              if (t_in > last_r) begin
                // whole seconds and leftover T-states of the elapsed time
                alu_req   = '{start: 1'b1, op: ALU_DIV, a: tick_t'(dt), b: hz};
                state_nxt = ST_SY_DIV;
              end else begin
                // time stood still or went back: no ticks, just follow now
                last_nxt  = t_in;
                state_nxt = ST_PUT;
              end
            end
            OP_DEADLINE: begin
              if (in_ch.busy_req) begin
                res_dv_nxt = 1'b1;
                if (in_ch.busy_until > total_r) begin
                  alu_req   = '{start: 1'b1, op: ALU_MUL,
                                a: in_ch.busy_until - total_r, b: hz};
                  state_nxt = ST_DL_MUL;
                end else begin
                  scr_nxt   = '0;
                  state_nxt = ST_DL_FIN;
                end
              end else begin
                state_nxt = ST_PUT;
              end
            end
            OP_RESTART: begin
              last_nxt  = t_in;
              total_nxt = '0;
              trem_nxt  = '0;
              state_nxt = ST_PUT;
            end
            default: begin
              // unused code: report the count, change nothing
              state_nxt = ST_PUT;
            end
          endcase
        end
      end

      ST_SY_DIV: begin
        if (alu_rsp.done) begin
          scr_nxt   = tick_t'(alu_rsp.rem);
          alu_req   = '{start: 1'b1, op: ALU_MUL, a: alu_rsp.res, b: hz_t'(f)};
          state_nxt = ST_SY_MULQ;
        end
      end

      ST_SY_MULQ: begin
        if (alu_rsp.done) begin
          // ticks of the whole seconds, wrapping mod 2^64
          total_nxt = total_r + alu_rsp.res;
          alu_req   = '{start: 1'b1, op: ALU_MUL, a: scr_r, b: hz_t'(f)};
          state_nxt = ST_SY_MULR;
        end
      end

      ST_SY_MULR: begin
        if (alu_rsp.done) begin
          // fold the carried remainder into the leftover ticks
          alu_req   = '{start: 1'b1, op: ALU_DIV,
                        a: alu_rsp.res + tick_t'(trem_r), b: hz};
          state_nxt = ST_SY_REM;
        end
      end

      ST_SY_REM: begin
        if (alu_rsp.done) begin
          total_nxt = total_r + alu_rsp.res;
          trem_nxt  = alu_rsp.rem;
          last_nxt  = pend_t_r;
          state_nxt = ST_PUT;
        end
      end

      ST_DL_MUL: begin
        if (alu_rsp.done) begin
          // T-states still owed, less the carried remainder
          scr_nxt   = alu_rsp.res - tick_t'(trem_r);
          state_nxt = ST_DL_ADJ;
        end
      end

      ST_DL_ADJ: begin
        // round the division up
        alu_req   = '{start: 1'b1, op: ALU_DIV, a: scr_r + tick_t'(f_m1), b: hz_t'(f)};
        state_nxt = ST_DL_DIV;
      end

      ST_DL_DIV: begin
        if (alu_rsp.done) begin
          scr_nxt   = alu_rsp.res;
          state_nxt = ST_DL_FIN;
        end
      end

      ST_DL_FIN: begin
        // a deadline not after now becomes now plus one
        if (when <= pend_t_r) begin
          res_dl_nxt = pend_t_r + 1'b1;
        end else begin
          res_dl_nxt = when;
        end
        state_nxt = ST_PUT;
      end

      ST_PUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_tick_nxt  = total_r;
          out_dl_nxt    = res_dl_r;
          out_dv_nxt    = res_dv_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cpu_hz_r    <= CPU_HZ_RST;
      mode_r      <= MODE_RST;
      access_r    <= ACCESS_RST;
      last_r      <= '0;
      total_r     <= '0;
      trem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cpu_hz_r    <= cpu_hz_nxt;
      mode_r      <= mode_nxt;
      access_r    <= access_nxt;
      last_r      <= last_nxt;
      total_r     <= total_nxt;
      trem_r      <= trem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_t_r   <= pend_t_nxt;
    scr_r      <= scr_nxt;
    res_dl_r   <= res_dl_nxt;
    res_dv_r   <= res_dv_nxt;
    out_tick_r <= out_tick_nxt;
    out_dl_r   <= out_dl_nxt;
    out_dv_r   <= out_dv_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.tick_count     = out_tick_r;
  assign out_ch.deadline       = tick_t'(out_dl_r);
  assign out_ch.deadline_valid = out_dv_r;

endmodule

// File: src/crtc_chk.sv
// Port-level checker for the clock ratio time converter, with its bind statement.
`timescale 1ns / 1ps

module crtc_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [63:0]           out_tick,
  input logic [63:0]           out_dl,
  input logic                  out_dv
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tick) && $stable(out_dl)
                                && $stable(out_dv))
    else $error("result changed while stalled");

  // no deadline value without its valid flag
  a_dl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dv |-> out_dl == 64'd0)
    else $error("deadline set without deadline_valid");

  // one request at a time: busy right after taking one
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

endmodule

bind clock_ratio_time_converter crtc_chk u_crtc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_tick  (out_ch.tick_count),
  .out_dl    (out_ch.deadline),
  .out_dv    (out_ch.deadline_valid)
);
